FILE: hw/rtl/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg: shared types and constants
// Neuron count, widths, word formats, codes and saturation for the network.
// ----------------------------------------------------------------------------
package lif_pkg;

  localparam int NEURONS        = 8;
  localparam int POTENTIAL_BITS = 16;
  localparam int IDX_W          = $clog2(NEURONS);
  localparam int CNT_W          = $clog2(NEURONS + 1);
  localparam int TAU_W          = 10;
  localparam int WADDR_W        = 2 * IDX_W;
  localparam int DIV_W          = POTENTIAL_BITS + 1;
  localparam int DIV_CNT_W      = $clog2(DIV_W);

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_LOAD_NEURON = 2'd1,
    ACT_LOAD_WEIGHT = 2'd2
  } action_e;

  localparam logic [2:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [2:0] CFG_REFRACTORY = 3'd1;
  localparam logic [2:0] CFG_ACTIVE     = 3'd2;
  localparam logic [2:0] CFG_MONITOR    = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_FAN_RD,
    ST_FAN_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         neuron_index;
    logic [2:0]         target_index;
    logic signed [15:0] value;
    logic [9:0]         time_constant;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         spike_mask;
    logic signed [15:0] monitor_potential;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [POTENTIAL_BITS-1:0] sat_pot(
      input logic signed [POTENTIAL_BITS+1:0] x);
    logic signed [POTENTIAL_BITS+1:0] hi;
    logic signed [POTENTIAL_BITS+1:0] lo;
    hi = {3'b000, {(POTENTIAL_BITS-1){1'b1}}};
    lo = {3'b111, {(POTENTIAL_BITS-1){1'b0}}};
    if (x > hi) begin
      return hi[POTENTIAL_BITS-1:0];
    end else if (x < lo) begin
      return lo[POTENTIAL_BITS-1:0];
    end
    return x[POTENTIAL_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/lif_ram.sv
// ----------------------------------------------------------------------------
// lif_ram: generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lif_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lif_div.sv
// ----------------------------------------------------------------------------
// lif_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module lif_div import lif_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [TAU_W-1:0]     divisor,
  output div_stat_t            stat,
  output logic [DIV_W-1:0]     quotient
);

  logic [DIV_W-1:0]     dq;
  logic [TAU_W-1:0]     rem;
  logic [TAU_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [TAU_W:0]       rem_s;
  logic                 ge;
  logic [TAU_W:0]       rem_sub;

  assign rem_s   = {rem, dq[DIV_W-1]};
  assign ge      = rem_s >= {1'b0, dvs};
  assign rem_sub = rem_s - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_sub[TAU_W-1:0] : rem_s[TAU_W-1:0];
      dq  <= {dq[DIV_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dq;

endmodule

FILE: hw/rtl/lif_neuron_network_step.sv
// ----------------------------------------------------------------------------
// lif_neuron_network_step: leaky integrate-and-fire network
// Loads neuron parameters and weights, and steps all active neurons per tick.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Content
//  in       input      in_valid / in_ready    tick or load word (in_word_t)
//  out      output     out_valid / out_ready  spike mask and monitor (out_word_t)
//  cfg      input      cfg_valid / cfg_ready  register index and data
//
// A load word is written when accepted. Per tick, each active neuron adds its
// pending input, then fires and fans its weights out to the active targets, or
// counts down refractory time, or leaks via the serial divider. Reset loads
// defaults, clears neuron state and weight flags; unwritten weights read zero.
// A finished result waits in the output register while the next word is taken.
module lif_neuron_network_step import lif_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  in_word_t                      in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output out_word_t                     out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int P = POTENTIAL_BITS;

  state_e state, state_next;

  logic signed [15:0] fire_threshold;
  logic [3:0]         refractory_ticks;
  logic [3:0]         active_neurons;
  logic [2:0]         monitor_neuron;

  logic signed [P-1:0] pot   [NEURONS];
  logic signed [P-1:0] pend  [NEURONS];
  logic [3:0]          refr  [NEURONS];
  logic signed [15:0]  drive [NEURONS];
  logic [TAU_W-1:0]    tau   [NEURONS];
  logic [NEURONS*NEURONS-1:0] wvalid;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    n_cnt;
  logic [CNT_W-1:0]    p_cnt;
  logic signed [P-1:0] vcur;
  logic                dneg;
  logic [7:0]          mask;
  logic signed [P-1:0] mon;
  logic                wv_q;

  logic [IDX_W-1:0]    n_idx;
  logic [IDX_W-1:0]    p_idx;
  logic [IDX_W-1:0]    pot_idx;
  logic [IDX_W-1:0]    pend_idx;
  logic signed [P-1:0] pot_rd;
  logic signed [P-1:0] pend_rd;
  logic signed [P-1:0] v_sum;
  logic                fire;
  logic signed [P+1:0] diff;
  logic [P+1:0]        diff_mag;
  logic [DIV_W-1:0]    quot;
  logic signed [P+1:0] dv;
  logic signed [P-1:0] v_leak;
  logic [CNT_W-1:0]    n_inc;
  logic [CNT_W-1:0]    p_inc;
  logic                last_n;
  logic                last_p;
  logic                div_start;
  div_stat_t           div_stat;
  logic                ram_we;
  logic [WADDR_W-1:0]  ram_waddr;
  logic [WADDR_W-1:0]  ram_raddr;
  logic [15:0]         ram_rdata;
  logic signed [15:0]  weight;
  logic                in_acc;
  logic                out_load;
  logic [CNT_W-1:0]    count_new;
  logic                src_ok;
  logic                dst_ok;

  assign in_ready  = state == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  assign n_idx    = n_cnt[IDX_W-1:0];
  assign p_idx    = p_cnt[IDX_W-1:0];
  assign pot_idx  = (state == ST_IDLE) ? monitor_neuron : n_idx;
  assign pend_idx = (state == ST_FAN_WR) ? p_idx : n_idx;
  assign pot_rd   = pot[pot_idx];
  assign pend_rd  = pend[pend_idx];

  assign v_sum    = sat_pot({{2{pot_rd[P-1]}}, pot_rd} + {{2{pend_rd[P-1]}}, pend_rd});
  assign fire     = v_sum > P'(fire_threshold);
  assign diff     = {{(P+2-16){drive[n_idx][15]}}, drive[n_idx]} - {{2{v_sum[P-1]}}, v_sum};
  assign diff_mag = diff[P+1] ? -diff : diff;
  assign dv       = dneg ? -{1'b0, quot} : {1'b0, quot};
  assign v_leak   = sat_pot({{2{vcur[P-1]}}, vcur} + dv);
  assign n_inc    = n_cnt + 1'b1;
  assign p_inc    = p_cnt + 1'b1;
  assign last_n   = n_inc == count;
  assign last_p   = p_inc == count;
  assign weight   = wv_q ? ram_rdata : 16'sd0;

  assign count_new = (active_neurons > CNT_W'(NEURONS)) ? CNT_W'(NEURONS)
                                                        : CNT_W'(active_neurons);
  assign src_ok    = 32'(in_word.neuron_index) < NEURONS;
  assign dst_ok    = 32'(in_word.target_index) < NEURONS;

  assign div_start = (state == ST_ADD) && !fire && (refr[n_idx] == 4'd0);
  assign ram_we    = in_acc && (in_word.action == ACT_LOAD_WEIGHT) && src_ok && dst_ok;
  assign ram_waddr = {in_word.neuron_index[IDX_W-1:0], in_word.target_index[IDX_W-1:0]};
  assign ram_raddr = {n_idx, p_idx};

  lif_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag[DIV_W-1:0]),
    .divisor  (tau[n_idx]),
    .stat     (div_stat),
    .quotient (quot)
  );

  lif_ram #(.WIDTH(16), .DEPTH(NEURONS * NEURONS)) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word.value),
    .re    (state == ST_FAN_RD),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_word.action == ACT_TICK) begin
          state_next = (count_new == '0) ? ST_DONE : ST_ADD;
        end
      end
      ST_ADD: begin
        if (fire) begin
          state_next = ST_FAN_RD;
        end else if (refr[n_idx] != 4'd0) begin
          state_next = last_n ? ST_DONE : ST_ADD;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = last_n ? ST_DONE : ST_ADD;
        end
      end
      ST_FAN_RD: state_next = ST_FAN_WR;
      ST_FAN_WR: begin
        if (!last_p) begin
          state_next = ST_FAN_RD;
        end else begin
          state_next = last_n ? ST_DONE : ST_ADD;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_threshold   <= 16'sd256;
      refractory_ticks <= 4'd3;
      active_neurons   <= 4'd3;
      monitor_neuron   <= 3'd2;
      out_valid        <= 1'b0;
      wvalid           <= '0;
      for (int i = 0; i < NEURONS; i++) begin
        pot[i]   <= '0;
        pend[i]  <= '0;
        refr[i]  <= '0;
        drive[i] <= '0;
        tau[i]   <= TAU_W'(1);
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD:  fire_threshold   <= cfg_data;
          CFG_REFRACTORY: refractory_ticks <= cfg_data[3:0];
          CFG_ACTIVE:     active_neurons   <= cfg_data[3:0];
          CFG_MONITOR:    monitor_neuron   <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (in_acc && in_word.action == ACT_LOAD_NEURON && src_ok) begin
        drive[in_word.neuron_index[IDX_W-1:0]] <= in_word.value;
        tau[in_word.neuron_index[IDX_W-1:0]]   <=
          (in_word.time_constant == '0) ? TAU_W'(1) : in_word.time_constant;
      end
      if (ram_we) begin
        wvalid[ram_waddr] <= 1'b1;
      end

      case (state)
        ST_ADD: begin
          pend[n_idx] <= '0;
          if (fire) begin
            refr[n_idx] <= refractory_ticks;
            pot[n_idx]  <= '0;
          end else if (refr[n_idx] != 4'd0) begin
            refr[n_idx] <= refr[n_idx] - 4'd1;
            pot[n_idx]  <= '0;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            pot[n_idx] <= v_leak;
          end
        end
        ST_FAN_WR: begin
          pend[p_idx] <= sat_pot({{2{pend_rd[P-1]}}, pend_rd} +
                                 {{(P+2-16){weight[15]}}, weight});
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_word.action == ACT_TICK) begin
      count <= count_new;
      n_cnt <= '0;
      mask  <= '0;
      mon   <= (CNT_W'(monitor_neuron) < count_new) ? '0 : pot_rd;
    end
    case (state)
      ST_ADD: begin
        vcur <= v_sum;
        dneg <= diff[P+1];
        p_cnt <= '0;
        if (n_idx == monitor_neuron) begin
          mon <= v_sum;
        end
        if (fire) begin
          mask[n_idx] <= 1'b1;
        end else if (refr[n_idx] != 4'd0) begin
          n_cnt <= n_inc;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          n_cnt <= n_inc;
        end
      end
      ST_FAN_RD: wv_q <= wvalid[ram_raddr];
      ST_FAN_WR: begin
        p_cnt <= p_inc;
        if (last_p) begin
          n_cnt <= n_inc;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_word.spike_mask        <= mask;
      out_word.monitor_potential <= mon;
    end
  end

  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_word.action == ACT_TICK |=> state != ST_IDLE)
    else $error("tick word did not start a pass");

  a_fan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FAN_RD |-> p_cnt < count && n_cnt < count)
    else $error("fan-out index beyond active count");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside the finish state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the leak step");

endmodule
